### src/ptag_pkg.sv
`default_nettype none
package ptag_pkg;

	localparam int SEQ_LEN = 20;
	localparam int CNT_W = $clog2(SEQ_LEN);
	localparam int GLYPH_DEPTH = 256;

	localparam logic [1:0] REG_COLOR_MODE = 2'd0;
	localparam logic [1:0] REG_ACCURATE_GRAY = 2'd1;
	localparam logic [1:0] REG_FILL_CHAR = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_TABLE_WRITE = 1'b1;

	localparam logic [15:0] W_RED = 16'd77;
	localparam logic [15:0] W_GREEN = 16'd150;
	localparam logic [15:0] W_BLUE = 16'd29;
	localparam logic [19:0] RECIP3 = 20'd683;
	localparam logic [13:0] RECIP100 = 14'd41;
	localparam logic [14:0] RECIP10 = 15'd205;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_BRACKET = 8'h5B;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_TWO = 8'h32;
	localparam logic [7:0] CH_M = 8'h6D;
	localparam logic [7:0] CH_ZERO = 8'h30;

	localparam logic RESET_COLOR_MODE = 1'b1;
	localparam logic RESET_ACCURATE_GRAY = 1'b0;
	localparam logic [7:0] RESET_FILL_CHAR = 8'd51;

	typedef struct packed {
		logic [1:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} dec_t;

	typedef struct packed {
		logic [7:0] glyph;
		dec_t [2:0] chan;
	} item_t;

	typedef struct packed {
		logic       color_mode;
		logic       accurate_gray;
		logic [7:0] fill_char;
	} cfg_t;

endpackage
`default_nettype wire

### src/ptag_ram.sv
`default_nettype none
module ptag_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### src/ptag_front.sv
`default_nettype none
module ptag_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           opcode,
	input  wire logic [7:0]     red,
	input  wire logic [7:0]     green,
	input  wire logic [7:0]     blue,
	input  wire logic [7:0]     entry_index,
	input  wire logic [7:0]     entry_glyph,
	input  wire logic           accurate_gray,
	output logic                item_valid,
	input  wire logic           item_ready,
	output ptag_pkg::item_t     item
);
	import ptag_pkg::*;

	function automatic logic [1:0] hund_of(input logic [7:0] v);
		logic [13:0] p;
		p = {6'b0, v} * RECIP100;
		return p[13:12];
	endfunction

	function automatic logic [6:0] rem_of(input logic [7:0] v, input logic [1:0] h);
		logic [7:0] hv;
		hv = {6'b0, h} * 8'd100;
		return 7'(v - hv);
	endfunction

	function automatic dec_t split_rem(input logic [1:0] h, input logic [6:0] r);
		logic [14:0] p;
		logic [3:0]  t;
		logic [6:0]  tv;
		dec_t        d;
		p = {8'b0, r} * RECIP10;
		t = p[14:11];
		tv = {3'b0, t} * 7'd10;
		d.hund = h;
		d.tens = t;
		d.ones = 4'(r - tv);
		return d;
	endfunction

	logic [2:0][7:0] rgb;
	logic [15:0]     sum_in;
	logic            adv;

	logic            valid_s1;
	logic            op_s1;
	logic [7:0]      idx_s1;
	logic [7:0]      gly_s1;
	logic [15:0]     sum_s1;
	logic [2:0][1:0] hund_s1;
	logic [2:0][6:0] rem_s1;

	logic [19:0]     div3_prod;
	logic [7:0]      gray;

	logic            valid_s2;
	logic            op_s2;
	logic [7:0]      idx_s2;
	logic [7:0]      gly_s2;
	logic [7:0]      gray_s2;
	dec_t [2:0]      dec_s2;

	logic            valid_s3;
	dec_t [2:0]      dec_s3;
	logic [7:0]      glyph_s3;

	assign rgb = {blue, green, red};
	assign adv = !valid_s3 || item_ready;
	assign in_ready = adv;

	// weighted luma or plain channel sum
	assign sum_in = accurate_gray
		? ({8'b0, red} * W_RED) + ({8'b0, green} * W_GREEN) + ({8'b0, blue} * W_BLUE)
		: 16'({8'b0, red}) + 16'({8'b0, green}) + 16'({8'b0, blue});

	// sum/3 via reciprocal, exact for sums up to 765
	assign div3_prod = {10'b0, sum_s1[9:0]} * RECIP3;
	assign gray = accurate_gray ? sum_s1[15:8] : div3_prod[18:11];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && (op_s2 == OP_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= opcode;
			idx_s1 <= entry_index;
			gly_s1 <= entry_glyph;
			sum_s1 <= sum_in;
			for (int c = 0; c < 3; c++) begin
				hund_s1[c] <= hund_of(rgb[c]);
				rem_s1[c] <= rem_of(rgb[c], hund_of(rgb[c]));
			end

			op_s2 <= op_s1;
			idx_s2 <= idx_s1;
			gly_s2 <= gly_s1;
			gray_s2 <= gray;
			for (int c = 0; c < 3; c++) begin
				dec_s2[c] <= split_rem(hund_s1[c], rem_s1[c]);
			end

			dec_s3 <= dec_s2;
		end
	end

	ptag_ram #(
		.WIDTH(8),
		.DEPTH(GLYPH_DEPTH)
	) u_glyph_ram (
		.clk  (clk),
		.we   (adv && valid_s2 && (op_s2 == OP_TABLE_WRITE)),
		.waddr(idx_s2),
		.wdata(gly_s2),
		.re   (adv),
		.raddr(gray_s2),
		.rdata(glyph_s3)
	);

	assign item_valid = valid_s3;
	assign item.glyph = glyph_s3;
	assign item.chan = dec_s3;

endmodule
`default_nettype wire

### src/ptag_ser.sv
`default_nettype none
module ptag_ser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ptag_pkg::cfg_t cfg,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire ptag_pkg::item_t item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_byte,
	output logic                last
);
	import ptag_pkg::*;

	logic                      busy_q;
	logic [CNT_W-1:0]          cnt_q;
	item_t                     item_q;
	logic                      load;
	logic [SEQ_LEN-1:0][7:0]   seq;

	assign out_valid = busy_q;
	assign last = !cfg.color_mode || (cnt_q == CNT_W'(SEQ_LEN - 1));
	assign item_ready = !busy_q || (out_ready && last);
	assign load = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q && out_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
	end

	// escape sequence, channels in decimal with leading zeros
	always_comb begin
		seq[0] = CH_ESC;
		seq[1] = CH_BRACKET;
		seq[2] = cfg.fill_char;
		seq[3] = CH_EIGHT;
		seq[4] = CH_SEMI;
		seq[5] = CH_TWO;
		seq[6] = CH_SEMI;
		for (int c = 0; c < 3; c++) begin
			seq[7 + 4 * c] = CH_ZERO + {6'b0, item_q.chan[c].hund};
			seq[8 + 4 * c] = CH_ZERO + {4'b0, item_q.chan[c].tens};
			seq[9 + 4 * c] = CH_ZERO + {4'b0, item_q.chan[c].ones};
		end
		seq[10] = CH_SEMI;
		seq[14] = CH_SEMI;
		seq[18] = CH_M;
		seq[19] = item_q.glyph;
	end

	assign out_byte = cfg.color_mode ? seq[cnt_q] : item_q.glyph;

endmodule
`default_nettype wire

### src/pixel_to_ansi_truecolor_glyph.sv
// channel  | handshake           | payload
// input    | in_valid, in_ready  | opcode, red, green, blue, entry_index, entry_glyph
// output   | out_valid, out_ready| out_byte, last
// config   | cfg_we              | cfg_index, cfg_data
//
// the first output byte of an accepted input transaction passes through
// two compute stages, the glyph ram read, then the output serializer register
// color mode: 20 output bytes per pixel, set by the byte-wide serializer;
// plain mode and table writes: one transaction per cycle while the output does not stall
// reset clears valid bits, serializer state and config registers; the glyph table holds no reset value
// an output stall holds the pipeline; three pixels can queue behind the serializer
`default_nettype none
module pixel_to_ansi_truecolor_glyph (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       opcode,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic [7:0] entry_index,
	input  wire logic [7:0] entry_glyph,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            last,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	import ptag_pkg::*;

	cfg_t  cfg_q;
	logic  item_valid;
	logic  item_ready;
	item_t item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_mode <= RESET_COLOR_MODE;
			cfg_q.accurate_gray <= RESET_ACCURATE_GRAY;
			cfg_q.fill_char <= RESET_FILL_CHAR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLOR_MODE: cfg_q.color_mode <= cfg_data[0];
				REG_ACCURATE_GRAY: cfg_q.accurate_gray <= cfg_data[0];
				REG_FILL_CHAR: cfg_q.fill_char <= cfg_data;
				default: ;
			endcase
		end
	end

	ptag_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.entry_index  (entry_index),
		.entry_glyph  (entry_glyph),
		.accurate_gray(cfg_q.accurate_gray),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item)
	);

	ptag_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
`default_nettype wire

### src/ptag_checker.sv
`default_nettype none
module ptag_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       last
);

	// a stalled output transaction holds its byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output changed while stalled");

	// bytes of one pixel follow with no gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a pixel sequence");

	// an empty serializer never blocks the input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output idle");

	// nothing comes out right after reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind pixel_to_ansi_truecolor_glyph ptag_checker u_ptag_checker (.*);
`default_nettype wire
